@@ rtl/afmod_pkg.sv @@
// ----------------------------------------------------------------------------
// AFSK frame modulator package
// Shared types, codes, constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package afmod_pkg;

  localparam int SAMPLES_PER_BIT = 40;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int LUT_ENTRIES     = 65;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;

  localparam logic [15:0] MARK_INCREMENT_RESET  = 16'd1638;
  localparam logic [15:0] SPACE_INCREMENT_RESET = 16'd3004;
  localparam logic [14:0] GAIN_RESET            = 15'd32767;
  localparam logic [15:0] SILENCE_LENGTH_RESET  = 16'd4800;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DATA       = 3'd1,
    OP_OPEN_FLAG  = 3'd2,
    OP_CLOSE_FLAG = 3'd3,
    OP_SILENCE    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_MARK_INCREMENT  = 2'd0,
    REG_SPACE_INCREMENT = 2'd1,
    REG_GAIN            = 2'd2,
    REG_SILENCE_LENGTH  = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               ready_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0] phase_idx;
    logic       active;
    logic       ready_res;
  } tick_t;

  typedef logic [14:0] sine_lut_t [LUT_ENTRIES];

  function automatic logic [14:0] sine_magnitude(input logic [31:0] x);
    logic [31:0] x2;
    logic [31:0] t;
    x2 = (x * x) >> 14;
    t  = (32'd153 * x2) >> 14;
    t  = ((32'd2611 - t) * x2) >> 14;
    t  = ((32'd21167 - t) * x2) >> 14;
    t  = ((32'd51472 - t) * x) >> 14;
    if (t > 32'd32767) begin
      t = 32'd32767;
    end
    return t[14:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int j = 0; j < LUT_ENTRIES; j++) begin
      lut[j] = sine_magnitude(32'(j) << 8);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ rtl/afmod_sine_gain.sv @@
// ----------------------------------------------------------------------------
// AFSK sine and gain stage
// Looks up the sine magnitude for a tick, scales it by the gain and holds the
// finished item in the output register.
// ----------------------------------------------------------------------------
module afmod_sine_gain (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  input  afmod_pkg::tick_t    tick,
  output logic                tick_stall,
  input  logic [14:0]         gain,
  output logic                out_valid,
  input  logic                out_stall,
  output afmod_pkg::out_item_t out_item
);

  logic        s1_valid;
  logic [14:0] s1_mag;
  logic        s1_neg;
  logic        s1_ready_res;
  logic        adv1;
  logic        adv2;
  logic [6:0]  lut_idx;
  logic [29:0] product;
  logic [15:0] magnitude;

  assign adv2       = !out_valid || !out_stall;
  assign adv1       = !s1_valid || adv2;
  assign tick_stall = !adv1;

  assign lut_idx   = tick.phase_idx[6] ? (7'd64 - {1'b0, tick.phase_idx[5:0]})
                                       : {1'b0, tick.phase_idx[5:0]};
  assign product   = {15'd0, s1_mag} * {15'd0, gain};
  assign magnitude = {1'b0, product[29:15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= tick_valid;
    end
    if (adv1 && tick_valid) begin
      s1_mag       <= tick.active ? afmod_pkg::SINE_LUT[lut_idx] : 15'd0;
      s1_neg       <= tick.active && tick.phase_idx[7];
      s1_ready_res <= tick.ready_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s1_valid;
    end
    if (adv2 && s1_valid) begin
      out_item.sample    <= s1_neg ? 16'(16'd0 - magnitude) : magnitude;
      out_item.ready_res <= s1_ready_res;
    end
  end

endmodule

@@ rtl/ax25_afsk_frame_modulator_unit.sv @@
// ----------------------------------------------------------------------------
// AX.25 AFSK frame modulator
// Serialises loaded bytes with zero stuffing and NRZI coding and turns each
// sample tick into a gained, phase-continuous sine sample.
// ----------------------------------------------------------------------------
// A sample tick's item passes through the table register and then the output
// register to out_item; loads give no item.
// Throughput: one item per cycle while out_stall is low, set by the two-stage table and multiplier path.
// Reset: synchronous; all state but the held sample data clears, the tone starts
// on mark and the registers take their default values.
module ax25_afsk_frame_modulator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  afmod_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output afmod_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] mark_increment;
  logic [15:0] space_increment;
  logic [14:0] gain;
  logic [15:0] silence_length;

  logic [7:0]  bit_shifter,       bit_shifter_next;
  logic [3:0]  bits_remaining,    bits_remaining_next;
  logic        is_flag_byte,      is_flag_byte_next;
  logic [2:0]  ones_run,          ones_run_next;
  logic        stuff_pending,     stuff_pending_next;
  logic        tone_is_space,     tone_is_space_next;
  logic [15:0] phase_accumulator, phase_accumulator_next;
  logic [5:0]  samples_in_bit,    samples_in_bit_next;
  logic [15:0] silence_remaining, silence_remaining_next;

  logic             accept;
  logic             idle;
  logic             tx_bit;
  logic             tick_valid;
  logic             tick_stall;
  afmod_pkg::tick_t tick;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_increment  <= afmod_pkg::MARK_INCREMENT_RESET;
      space_increment <= afmod_pkg::SPACE_INCREMENT_RESET;
      gain            <= afmod_pkg::GAIN_RESET;
      silence_length  <= afmod_pkg::SILENCE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (afmod_pkg::reg_index_e'(cfg_index))
        afmod_pkg::REG_MARK_INCREMENT:  mark_increment  <= cfg_data;
        afmod_pkg::REG_SPACE_INCREMENT: space_increment <= cfg_data;
        afmod_pkg::REG_GAIN:            gain            <= cfg_data[14:0];
        afmod_pkg::REG_SILENCE_LENGTH:  silence_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = tick_stall;
  assign accept   = in_valid && !in_stall;
  assign idle     = (silence_remaining == 16'd0) && (bits_remaining == 4'd0) &&
                    !stuff_pending && (samples_in_bit == 6'd0);

  always_comb begin
    bit_shifter_next       = bit_shifter;
    bits_remaining_next    = bits_remaining;
    is_flag_byte_next      = is_flag_byte;
    ones_run_next          = ones_run;
    stuff_pending_next     = stuff_pending;
    tone_is_space_next     = tone_is_space;
    phase_accumulator_next = phase_accumulator;
    samples_in_bit_next    = samples_in_bit;
    silence_remaining_next = silence_remaining;
    tick_valid             = 1'b0;
    tick.active            = 1'b0;
    tx_bit                 = 1'b0;
    if (accept) begin
      case (in_item.operation)
        afmod_pkg::OP_TICK: begin
          tick_valid = 1'b1;
          if (silence_remaining != 16'd0) begin
            silence_remaining_next = silence_remaining - 16'd1;
          end else if (!idle) begin
            tick.active = 1'b1;
            if (samples_in_bit == 6'd0) begin
              if (stuff_pending) begin
                tx_bit             = 1'b0;
                stuff_pending_next = 1'b0;
              end else begin
                tx_bit              = bit_shifter[0];
                bit_shifter_next    = {1'b0, bit_shifter[7:1]};
                bits_remaining_next = bits_remaining - 4'd1;
                if (!is_flag_byte) begin
                  if (!tx_bit) begin
                    ones_run_next = 3'd0;
                  end else if (ones_run >= 3'd4) begin
                    ones_run_next      = 3'd0;
                    stuff_pending_next = 1'b1;
                  end else begin
                    ones_run_next = ones_run + 3'd1;
                  end
                end
              end
              if (!tx_bit) begin
                tone_is_space_next = !tone_is_space;
              end
            end
            phase_accumulator_next = phase_accumulator +
                                     (tone_is_space_next ? space_increment : mark_increment);
            if (samples_in_bit == 6'(afmod_pkg::SAMPLES_PER_BIT - 1)) begin
              samples_in_bit_next = 6'd0;
            end else begin
              samples_in_bit_next = samples_in_bit + 6'd1;
            end
          end
        end
        afmod_pkg::OP_DATA: begin
          if (idle) begin
            bit_shifter_next    = in_item.data_byte;
            bits_remaining_next = 4'd8;
            is_flag_byte_next   = 1'b0;
          end
        end
        afmod_pkg::OP_OPEN_FLAG: begin
          if (idle) begin
            bit_shifter_next    = afmod_pkg::FLAG_BYTE;
            bits_remaining_next = 4'd8;
            is_flag_byte_next   = 1'b1;
            ones_run_next       = 3'd0;
          end
        end
        afmod_pkg::OP_CLOSE_FLAG: begin
          if (idle) begin
            bit_shifter_next    = afmod_pkg::FLAG_BYTE;
            bits_remaining_next = 4'd8;
            is_flag_byte_next   = 1'b1;
          end
        end
        afmod_pkg::OP_SILENCE: begin
          if (idle) begin
            silence_remaining_next = silence_length;
          end
        end
        default: ;
      endcase
    end
    tick.phase_idx = phase_accumulator[15:8];
    tick.ready_res = (silence_remaining_next == 16'd0) && (bits_remaining_next == 4'd0) &&
                     !stuff_pending_next && (samples_in_bit_next == 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shifter       <= 8'd0;
      bits_remaining    <= 4'd0;
      is_flag_byte      <= 1'b0;
      ones_run          <= 3'd0;
      stuff_pending     <= 1'b0;
      tone_is_space     <= 1'b0;
      phase_accumulator <= 16'd0;
      samples_in_bit    <= 6'd0;
      silence_remaining <= 16'd0;
    end else begin
      bit_shifter       <= bit_shifter_next;
      bits_remaining    <= bits_remaining_next;
      is_flag_byte      <= is_flag_byte_next;
      ones_run          <= ones_run_next;
      stuff_pending     <= stuff_pending_next;
      tone_is_space     <= tone_is_space_next;
      phase_accumulator <= phase_accumulator_next;
      samples_in_bit    <= samples_in_bit_next;
      silence_remaining <= silence_remaining_next;
    end
  end

  afmod_sine_gain u_sine_gain (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_stall (tick_stall),
    .gain       (gain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
